>>> hw/rtl/lbs_pkg.sv
`timescale 1ns / 1ps
package lbs_pkg;

   // matrix layout
   localparam int ENTRIES_PER_JOINT = 12;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // weight of one in Q1.16
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_VERTEX = 1'b1;

   // register file
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_THRESHOLD   = 1'b0;
   localparam logic [16:0] THRESHOLD_RESET = 17'd1;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_APPLY,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic               cmd;
      logic [4:0]         joint;
      logic [3:0]         entry;
      logic signed [31:0] value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [4:0]         joint;
      logic [3:0]         entry;
      logic signed [31:0] value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last;
   } job_type;

endpackage

>>> hw/rtl/lbs_front.sv
`timescale 1ns / 1ps
module lbs_front #(
   parameter int MAX_JOINTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbs_pkg::req_type req_data,
   input  logic [16:0]      threshold,
   input  logic             queue_full,
   output logic             push_valid,
   output lbs_pkg::job_type push_job
);
   import lbs_pkg::*;

   logic    hold_v_ff;
   job_type hold_ff;
   logic    joint_ok;
   logic    keep;
   logic    accept;
   job_type job_in;

   // classify the incoming item
   always_comb begin
      joint_ok      = 32'(req_data.joint) < 32'(MAX_JOINTS);
      job_in.op     = OP_LOAD;
      job_in.joint  = req_data.joint;
      job_in.entry  = req_data.entry;
      job_in.value  = req_data.value;
      job_in.pos_x  = req_data.pos_x;
      job_in.pos_y  = req_data.pos_y;
      job_in.pos_z  = req_data.pos_z;
      job_in.weight = (req_data.weight > WEIGHT_ONE) ? WEIGHT_ONE : req_data.weight;
      job_in.last   = req_data.last;
      keep          = 1'b0;
      if (req_data.cmd == CMD_LOAD) begin
         keep = joint_ok && (32'(req_data.entry) < 32'(ENTRIES_PER_JOINT));
      end else if (joint_ok && (req_data.weight >= threshold)) begin
         job_in.op = OP_APPLY;
         keep      = 1'b1;
      end else if (req_data.last) begin
         // skipped contribution that still closes the vertex
         job_in.op = OP_EMIT;
         keep      = 1'b1;
      end
   end

   // handshake with the queue
   assign push_valid = hold_v_ff && !queue_full;
   assign push_job   = hold_ff;
   assign req_stall  = hold_v_ff && queue_full;
   assign accept     = req_valid && !req_stall;

   // holding stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else if (accept) begin
         hold_v_ff <= keep;
      end else if (push_valid) begin
         hold_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= job_in;
      end
   end

endmodule

>>> hw/rtl/lbs_queue.sv
`timescale 1ns / 1ps
module lbs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lbs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output lbs_pkg::job_type pop_job
);
   import lbs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type       slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          do_push;
   logic          do_pop;

   assign full      = count_ff == (PW + 1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_job   = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/lbs_back.sv
`timescale 1ns / 1ps
module lbs_back #(
   parameter int MAX_JOINTS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  lbs_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lbs_pkg::rsp_type rsp_data
);
   import lbs_pkg::*;

   localparam int DEPTH = MAX_JOINTS * ENTRIES_PER_JOINT;
   localparam int AW    = $clog2(DEPTH);
   // row sum of three shifted products and an offset always fits here
   localparam int TW    = 66;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
   localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   // matrix store
   logic [31:0]   matrix_mem [DEPTH];
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   rdata_ff;

   state_type          state_ff;
   job_type            cur_ff;
   logic [AW-1:0]      base_ff;
   logic [3:0]         rd_cnt_ff;
   logic               a_v_ff;
   logic [3:0]         a_e_ff;
   logic               b_v_ff;
   logic [3:0]         b_e_ff;
   logic signed [TW-1:0] term_ff;
   logic signed [TW-1:0] t_ff;
   logic               c_v_ff;
   logic [1:0]         c_row_ff;
   logic signed [47:0] tsat_ff;
   logic               d_v_ff;
   logic [1:0]         d_row_ff;
   logic signed [65:0] wprod_ff;
   logic signed [47:0] sum_x_ff;
   logic signed [47:0] sum_y_ff;
   logic signed [47:0] sum_z_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic signed [31:0]   pos_sel;
   logic signed [63:0]   prod;
   logic signed [TW-1:0] term_in;
   logic signed [TW-1:0] t_full;
   logic signed [47:0]   tsat_in;
   logic signed [17:0]   w_s;
   logic signed [47:0]   sum_old;
   logic signed [49:0]   sum_wide;
   logic signed [47:0]   sum_in;
   logic                 issue_done;
   logic                 drained;
   logic                 out_free;
   rsp_type              rsp_in;
   logic                 sat_x;
   logic                 sat_y;
   logic                 sat_z;

   function automatic logic [AW-1:0] joint_base(input logic [4:0] j);
      logic [15:0] b;
      b = 16'(j) * 16'(ENTRIES_PER_JOINT);
      return AW'(b);
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [47:0] s,
                                                 output logic sat);
      logic signed [31:0] r;
      sat = 1'b1;
      if (s > 48'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (s < 48'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r   = s[31:0];
         sat = 1'b0;
      end
      return r;
   endfunction

   // memory port control
   assign job_pop    = (state_ff == ST_IDLE) && job_valid;
   assign wr_en      = job_pop && (job.op == OP_LOAD);
   assign wr_addr    = joint_base(job.joint) + AW'(job.entry);
   assign issue_done = rd_cnt_ff == 4'(ENTRIES_PER_JOINT);
   assign rd_en      = (state_ff == ST_RUN) && !issue_done;
   assign rd_addr    = base_ff + AW'(rd_cnt_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         matrix_mem[wr_addr] <= job.value;
      end
      if (rd_en) begin
         rdata_ff <= matrix_mem[rd_addr];
      end
   end

   // stage a: one product per matrix entry, the offset column passes through
   always_comb begin
      case (a_e_ff[1:0])
         2'd0:    pos_sel = cur_ff.pos_x;
         2'd1:    pos_sel = cur_ff.pos_y;
         2'd2:    pos_sel = cur_ff.pos_z;
         default: pos_sel = '0;
      endcase
      prod = $signed(rdata_ff) * pos_sel;
      if (a_e_ff[1:0] == 2'd3) begin
         term_in = TW'($signed(rdata_ff));
      end else begin
         term_in = TW'(prod >>> FRAC_BITS);
      end
   end

   // stage b: row sum and clamp to accumulator range
   always_comb begin
      t_full = t_ff + term_ff;
      if (t_full > TW'(ACC_MAX)) begin
         tsat_in = ACC_MAX;
      end else if (t_full < TW'(ACC_MIN)) begin
         tsat_in = ACC_MIN;
      end else begin
         tsat_in = t_full[47:0];
      end
   end

   // stage d: weighted row into its accumulator
   always_comb begin
      w_s = $signed({1'b0, cur_ff.weight});
      case (d_row_ff)
         2'd0:    sum_old = sum_x_ff;
         2'd1:    sum_old = sum_y_ff;
         default: sum_old = sum_z_ff;
      endcase
      sum_wide = 50'(sum_old) + 50'(wprod_ff >>> 16);
      if (sum_wide > 50'(ACC_MAX)) begin
         sum_in = ACC_MAX;
      end else if (sum_wide < 50'(ACC_MIN)) begin
         sum_in = ACC_MIN;
      end else begin
         sum_in = sum_wide[47:0];
      end
   end

   // result clipping
   always_comb begin
      rsp_in.out_x     = clip32(sum_x_ff, sat_x);
      rsp_in.out_y     = clip32(sum_y_ff, sat_y);
      rsp_in.out_z     = clip32(sum_z_ff, sat_z);
      rsp_in.saturated = sat_x || sat_y || sat_z;
   end

   assign drained  = issue_done && !a_v_ff && !b_v_ff && !c_v_ff && !d_v_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, datapath stages and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= 4'(ENTRIES_PER_JOINT);
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         t_ff         <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register loads on emit, otherwise drains independently
         if ((state_ff == ST_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // read issue
         a_v_ff <= rd_en;
         a_e_ff <= rd_cnt_ff;
         if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end

         // stage a to b
         b_v_ff  <= a_v_ff;
         b_e_ff  <= a_e_ff;
         term_ff <= term_in;

         // stage b to c
         c_v_ff <= b_v_ff && (b_e_ff[1:0] == 2'd3);
         if (b_v_ff) begin
            if (b_e_ff[1:0] == 2'd3) begin
               tsat_ff  <= tsat_in;
               c_row_ff <= b_e_ff[3:2];
               t_ff     <= '0;
            end else begin
               t_ff <= t_full;
            end
         end

         // stage c to d
         d_v_ff   <= c_v_ff;
         d_row_ff <= c_row_ff;
         wprod_ff <= tsat_ff * w_s;

         // accumulate
         if (d_v_ff) begin
            case (d_row_ff)
               2'd0:    sum_x_ff <= sum_in;
               2'd1:    sum_y_ff <= sum_in;
               default: sum_z_ff <= sum_in;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (job_pop) begin
                  cur_ff <= job;
                  unique case (job.op)
                     OP_LOAD: begin
                        state_ff <= ST_IDLE;
                     end
                     OP_APPLY: begin
                        base_ff   <= joint_base(job.joint);
                        rd_cnt_ff <= '0;
                        state_ff  <= ST_RUN;
                     end
                     OP_EMIT: begin
                        state_ff <= ST_EMIT;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_RUN: begin
               if (drained) begin
                  state_ff <= cur_ff.last ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff   <= rsp_in;
                  sum_x_ff <= '0;
                  sum_y_ff <= '0;
                  sum_z_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/linear_blend_vertex_skinning_core.sv
`timescale 1ns / 1ps
// Linear blend skinning core. Matrix loads and vertex contributions enter on
// the req_ channel; the front stage classifies each item (load, weighted
// contribution, or a skipped contribution that only closes the vertex) and
// drops those that do nothing, then a four-deep queue feeds the back end.
// In the back end, a weighted contribution streams the twelve matrix entries
// out of the matrix store one per cycle, followed by a multiply, row-sum,
// weight and accumulate tail; a closing item then moves the clipped position
// into the output register. The matrix store has no clearing pass and reads
// of unloaded entries are undefined.
// The weight threshold register sits at byte address 0 of the csr_ port.
module linear_blend_vertex_skinning_core #(
   parameter int MAX_JOINTS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lbs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lbs_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import lbs_pkg::*;

   logic [16:0] threshold_ff;
   logic        csr_hit;
   logic        push_valid;
   job_type     push_job;
   logic        queue_full;
   logic        job_valid;
   job_type     job;
   logic        job_pop;

   // register file
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1] == CSR_THRESHOLD;
   assign csr_prdata = csr_hit ? 32'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         threshold_ff <= csr_pwdata[16:0];
      end
   end

   // front end
   lbs_front #(
      .MAX_JOINTS(MAX_JOINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_job  (push_job)
   );

   // decoupling queue
   lbs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .not_empty(job_valid),
      .pop_job  (job)
   );

   // back end
   lbs_back #(
      .MAX_JOINTS(MAX_JOINTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(job_valid),
      .job      (job),
      .job_pop  (job_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import lbs_pkg::*;

   localparam int MAX_JOINTS    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int SETTLE_CYCLES = 150;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 260;

   localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_MIN = -ACC_MAX - 1;
   localparam longint OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   localparam logic signed [31:0] Q_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE       = 32'sd65536;
   localparam logic signed [31:0] TRANSLATE_Q = 32'sd98304;

   localparam int LOW_JOINT  = MAX_JOINTS - 2;
   localparam int HIGH_JOINT = MAX_JOINTS - 1;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = CSR_ADDR_W'(4 * CSR_THRESHOLD);

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // skinning state mirrored by the testbench
   logic signed [31:0] joint_matrix [MAX_JOINTS][ENTRIES_PER_JOINT];
   longint             blend_sum [3] = '{0, 0, 0};
   logic [16:0]        threshold_model = THRESHOLD_RESET;
   rsp_type            expected_vertices [$];

   int   error_count   = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic holding       = 1'b0;
   event start_hold;

   linear_blend_vertex_skinning_core #(
      .MAX_JOINTS(MAX_JOINTS),
      .FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // blend one accepted item into the sums, queue the vertex on its closing item
   function automatic void skin_model(input req_type it);
      longint  pos [3];
      longint  t;
      longint  w;
      longint  c;
      logic    sat;
      rsp_type vertex;
      if (it.cmd == CMD_LOAD) begin
         if (it.entry < ENTRIES_PER_JOINT && it.joint < MAX_JOINTS)
            joint_matrix[it.joint][it.entry] = it.value;
         return;
      end
      pos[0] = longint'(it.pos_x);
      pos[1] = longint'(it.pos_y);
      pos[2] = longint'(it.pos_z);
      if (it.joint < MAX_JOINTS && it.weight >= threshold_model) begin
         w = longint'((it.weight > WEIGHT_ONE) ? WEIGHT_ONE : it.weight);
         for (int r = 0; r < 3; r++) begin
            t = longint'(joint_matrix[it.joint][r * 4 + 3]);
            for (int k = 0; k < 3; k++)
               t += (longint'(joint_matrix[it.joint][r * 4 + k]) * pos[k]) >>> FRAC_BITS;
            t = clip(t, ACC_MIN, ACC_MAX);
            blend_sum[r] = clip(blend_sum[r] + ((t * w) >>> WEIGHT_BITS), ACC_MIN, ACC_MAX);
         end
      end
      if (!it.last)
         return;
      // clip to the output range and clear the sums
      sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         c = clip(blend_sum[r], OUT_MIN, OUT_MAX);
         if (c != blend_sum[r])
            sat = 1'b1;
         case (r)
            0: vertex.out_x = c[31:0];
            1: vertex.out_y = c[31:0];
            default: vertex.out_z = c[31:0];
         endcase
         blend_sum[r] = 0;
      end
      vertex.saturated = sat;
      expected_vertices.insert(expected_vertices.size(), vertex);
   endfunction

   // item builders, unused fields carry random junk
   function automatic req_type load_item(input logic [4:0] joint, input logic [3:0] entry,
                                         input logic signed [31:0] value);
      req_type it;
      it.cmd    = CMD_LOAD;
      it.joint  = joint;
      it.entry  = entry;
      it.value  = value;
      it.pos_x  = $urandom();
      it.pos_y  = $urandom();
      it.pos_z  = $urandom();
      it.weight = 17'($urandom_range(0, 131071));
      it.last   = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_type vertex_item(input logic [4:0] joint,
                                           input logic signed [31:0] px, py, pz,
                                           input logic [16:0] weight, input logic last);
      req_type it;
      it.cmd    = CMD_VERTEX;
      it.joint  = joint;
      it.entry  = 4'($urandom_range(0, 15));
      it.value  = $urandom();
      it.pos_x  = px;
      it.pos_y  = py;
      it.pos_z  = pz;
      it.weight = weight;
      it.last   = last;
      return it;
   endfunction

   function automatic logic signed [31:0] random_position();
      int v;
      if ($urandom_range(9) < 7) begin
         v = int'($urandom_range(0, 16777216)) - 8388608;
         return v;
      end
      return $urandom();
   endfunction

   function automatic logic signed [31:0] random_matrix_value();
      int v;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60)
         v = int'($urandom_range(0, 262144)) - 131072;
      else if (pick < 85)
         v = int'($urandom_range(0, 33554432)) - 16777216;
      else
         v = $urandom();
      return v;
   endfunction

   function automatic logic [16:0] random_weight();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return 17'($urandom_range(0, 65536));
      else if (pick < 75)
         return WEIGHT_ONE;
      else if (pick < 85)
         return 17'($urandom_range(0, 16));
      return 17'($urandom_range(0, 131071));
   endfunction

   function automatic logic signed [31:0] px_rand();
      return random_position();
   endfunction

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      skin_model(it);
   endtask

   task automatic send_random_contribution(input logic last);
      send_item(vertex_item(5'($urandom_range(0, MAX_JOINTS - 1)), random_position(),
                            random_position(), random_position(), random_weight(), last));
   endtask

   // let every expected vertex come out, then give trailing work time to finish
   task automatic wait_block_idle();
      req_valid <= 1'b0;
      while (expected_vertices.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= THRESHOLD_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready)
         @(negedge clock);
      rdata = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_threshold(input logic [16:0] value);
      logic [31:0] readback;
      wait_block_idle();
      csr_access(1'b1, {15'd0, value}, readback);
      threshold_model = value;
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      if (readback !== {15'd0, value}) begin
         $error("weight_threshold: expected %0d, got %0d", value, readback);
         error_count++;
      end
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < rsp_stall_pct);
   end

   // long receiver hold-off, counted here
   initial forever begin
      @(start_hold);
      holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      holding <= 1'b0;
   end

   // result checking, sampled on the falling edge ahead of the accepting edge
   always @(negedge clock) begin : check_vertex
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vertices.size() == 0) begin
            $error("unexpected vertex: x=%0d y=%0d z=%0d saturated=%0d",
                   rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.saturated);
            error_count++;
         end else begin
            want = expected_vertices.pop_front();
            compare_field("out_x", 64'(want.out_x), 64'(rsp_data.out_x));
            compare_field("out_y", 64'(want.out_y), 64'(rsp_data.out_y));
            compare_field("out_z", 64'(want.out_z), 64'(rsp_data.out_z));
            compare_field("saturated", 64'(want.saturated), 64'(rsp_data.saturated));
         end
      end
   end

   task automatic test_reset_value();
      logic [31:0] readback;
      csr_access(1'b0, '0, readback);
      if (readback !== {15'd0, THRESHOLD_RESET}) begin
         $error("weight_threshold: expected %0d, got %0d", THRESHOLD_RESET, readback);
         error_count++;
      end
   endtask

   // every joint gets a full matrix before any vertex reads one
   task automatic test_matrix_load();
      logic signed [31:0] value;
      for (int j = 0; j < MAX_JOINTS; j++) begin
         for (int e = 0; e < ENTRIES_PER_JOINT; e++) begin
            if (j == 0)
               value = (e % 5 == 0) ? Q_ONE : ((e % 4 == 3) ? TRANSLATE_Q : 32'sd0);
            else if (j == LOW_JOINT)
               value = Q_MIN;
            else if (j == HIGH_JOINT)
               value = Q_MAX;
            else
               value = random_matrix_value();
            send_item(load_item(5'(j), 4'(e), value));
         end
      end
      // entries past the end of a matrix are dropped
      for (int e = ENTRIES_PER_JOINT; e < 16; e++)
         send_item(load_item(5'($urandom_range(0, MAX_JOINTS - 1)), 4'(e), $urandom()));
      wait_block_idle();
   endtask

   task automatic test_directed_cases();
      req_type            it;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      // identity joint with translation
      send_item(vertex_item(5'd0, 32'sd65536, 32'sd131072, 32'sd196608, WEIGHT_ONE, 1'b1));
      // half and half over two joints
      px = random_position();
      py = random_position();
      pz = random_position();
      send_item(vertex_item(5'd0, px, py, pz, 17'd32768, 1'b0));
      send_item(vertex_item(5'd1, px, py, pz, 17'd32768, 1'b1));
      // extreme matrices against extreme positions
      send_item(vertex_item(5'(HIGH_JOINT), Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 1'b1));
      send_item(vertex_item(5'(LOW_JOINT), Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 1'b1));
      send_item(vertex_item(5'(LOW_JOINT), Q_MIN, Q_MIN, Q_MIN, WEIGHT_ONE, 1'b1));
      send_item(vertex_item(5'(HIGH_JOINT), Q_MIN, Q_MIN, Q_MIN, WEIGHT_ONE, 1'b1));
      // vertex made only of a skipped weight
      send_item(vertex_item(5'd2, random_position(), random_position(), random_position(),
                            17'd0, 1'b1));
      // weights above one
      send_item(vertex_item(5'd0, px, py, pz, 17'h1FFFF, 1'b1));
      send_item(vertex_item(5'd0, px, py, pz, 17'd65537, 1'b1));
      // accumulator runs into its limit
      send_item(vertex_item(5'(HIGH_JOINT), Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 1'b0));
      send_item(vertex_item(5'(HIGH_JOINT), Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 1'b0));
      send_item(vertex_item(5'(HIGH_JOINT), Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 1'b1));
      // small negative position at the smallest weight, rounding goes down
      send_item(vertex_item(5'd0, -32'sd1, -32'sd1, -32'sd1, 17'd1, 1'b1));
      // skipped weight ahead of a weighted closing item
      send_item(vertex_item(5'd4, px, py, pz, 17'd0, 1'b0));
      send_item(vertex_item(5'd4, px, py, pz, WEIGHT_ONE, 1'b1));
      // loads never close a vertex
      it = load_item(5'd5, 4'd12, $urandom());
      it.last = 1'b1;
      send_item(it);
      it = load_item(5'd5, 4'd15, $urandom());
      it.last = 1'b1;
      send_item(it);
      wait_block_idle();
   endtask

   task automatic test_threshold_extremes();
      logic [16:0] mid;
      set_threshold(17'd0);
      send_item(vertex_item(5'd3, px_rand(), px_rand(), px_rand(), 17'd0, 1'b0));
      send_item(vertex_item(5'd3, px_rand(), px_rand(), px_rand(), 17'd5, 1'b1));
      set_threshold(WEIGHT_ONE);
      send_item(vertex_item(5'd6, px_rand(), px_rand(), px_rand(), 17'd65535, 1'b0));
      send_item(vertex_item(5'd7, px_rand(), px_rand(), px_rand(), WEIGHT_ONE, 1'b0));
      send_item(vertex_item(5'd8, px_rand(), px_rand(), px_rand(), 17'h1FFFF, 1'b1));
      mid = 17'($urandom_range(2, 65535));
      set_threshold(mid);
      send_item(vertex_item(5'd9, px_rand(), px_rand(), px_rand(), mid - 17'd1, 1'b0));
      send_item(vertex_item(5'd10, px_rand(), px_rand(), px_rand(), mid, 1'b1));
      set_threshold(THRESHOLD_RESET);
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_long_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> start_hold;
      for (int i = 0; i < 40; i++)
         send_random_contribution(1'b1);
      wait_block_idle();
   endtask

   task automatic test_random_traffic();
      int          sent;
      int          pick;
      int          count;
      logic [3:0]  entry;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               set_threshold(THRESHOLD_RESET);
            end
            1: begin
               send_idle_pct = 72;
               rsp_stall_pct = 0;
               set_threshold(17'($urandom_range(1, 40000)));
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 72;
               set_threshold(17'd0);
            end
            default: begin
               send_idle_pct = 32;
               rsp_stall_pct = 32;
               set_threshold(THRESHOLD_RESET);
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // matrix reload, sometimes to an entry that does not exist
               entry = ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, ENTRIES_PER_JOINT - 1));
               send_item(load_item(5'($urandom_range(0, MAX_JOINTS - 1)), entry,
                                   random_matrix_value()));
               if (entry < ENTRIES_PER_JOINT)
                  sent++;
            end else if (pick < 14) begin
               send_random_contribution(1'($urandom_range(1)));
               sent++;
            end else begin
               count = $urandom_range(1, 4);
               for (int k = 0; k < count; k++)
                  send_random_contribution(k == count - 1);
               sent += count;
            end
         end
         wait_block_idle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_matrix_load();
      test_directed_cases();
      test_threshold_extremes();
      test_long_stall();
      test_random_traffic();
      wait_block_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
